// File: hdl/clause_truth_table_filter_macros.svh
// Assertion macros for the clause truth table filter checker.
// No dependencies; included by the checker file.
`ifndef CLAUSE_TRUTH_TABLE_FILTER_MACROS_SVH
`define CLAUSE_TRUTH_TABLE_FILTER_MACROS_SVH

// Implication checked every cycle outside reset.
`define CTTF_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cttf assertion failed");

// Next-cycle implication, also checked during reset.
`define CTTF_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("cttf assertion failed");

`endif

// File: hdl/cttf_pkg.sv
// Shared types, constants and functions of the clause truth table filter.
// No dependencies.
`timescale 1ns / 1ps

package cttf_pkg;

   localparam int MAX_VARS_DEF = 10;
   localparam int LANE_VARS    = 6;     // variables resolved inside one 64-bit word
   localparam int WORD_W       = 64;
   localparam int VAR_W        = 4;
   localparam int COUNT_W      = 11;
   localparam int SHIFT_W      = 3;
   localparam int POL_W        = 3;
   localparam int WORD_IDX_W   = 4;

   localparam logic [VAR_W-1:0] VAR_LANE_LIMIT = 4'd6;
   localparam logic [VAR_W-1:0] VAR_LIMIT      = 4'd10;

   localparam logic [WORD_W-1:0] LANE_MASK [LANE_VARS] = '{
      64'h5555555555555555,
      64'h3333333333333333,
      64'h0f0f0f0f0f0f0f0f,
      64'h00ff00ff00ff00ff,
      64'h0000ffff0000ffff,
      64'h00000000ffffffff
   };

   typedef enum logic {
      OP_INIT   = 1'b0,
      OP_CLAUSE = 1'b1
   } op_type;

   // Item as it travels down the cell row.
   typedef struct packed {
      logic                    valid;
      op_type                  op;
      logic [SHIFT_W-1:0]      shift;   // log2 of the words that init sets
      logic [VAR_W-1:0]        var_a;
      logic [VAR_W-1:0]        var_b;
      logic [VAR_W-1:0]        var_c;
      logic [POL_W-1:0]        pol;
   } item_type;

   // Bits of a word in which the literal holds.
   function automatic logic [WORD_W-1:0] lit_keep(
      input logic [VAR_W-1:0]      v,
      input logic                  neg,
      input logic [WORD_IDX_W-1:0] word
   );
      logic [WORD_W-1:0] z;
      logic [VAR_W-1:0]  d;
      d = v - VAR_LANE_LIMIT;
      if (v < VAR_LANE_LIMIT) begin
         z = LANE_MASK[v[2:0]];
      end else if (v < VAR_LIMIT) begin
         z = word[d[1:0]] ? '0 : '1;
      end else begin
         z = '1;
      end
      return neg ? ~z : z;
   endfunction

   // Parallel bit count, six mask-and-add levels.
   function automatic logic [6:0] pop64(input logic [WORD_W-1:0] x);
      logic [WORD_W-1:0] x1, x2, x3, x4, x5, x6;
      x1 = x - ((x >> 1) & LANE_MASK[0]);
      x2 = (x1 & LANE_MASK[1]) + ((x1 >> 2) & LANE_MASK[1]);
      x3 = (x2 + (x2 >> 4)) & LANE_MASK[2];
      x4 = x3 + (x3 >> 8);
      x5 = x4 + (x4 >> 16);
      x6 = x5 + (x5 >> 32);
      return x6[6:0];
   endfunction

endpackage

// File: hdl/cttf_req_if.sv
// Request and response channel interfaces of the clause truth table filter.
// Depends on cttf_pkg for field widths.
`timescale 1ns / 1ps

interface cttf_req_if;
   logic                        valid;
   logic                        ready;
   logic                        operation;
   logic [cttf_pkg::VAR_W-1:0]  var_count;
   logic [cttf_pkg::VAR_W-1:0]  first_var;
   logic [cttf_pkg::VAR_W-1:0]  second_var;
   logic [cttf_pkg::VAR_W-1:0]  third_var;
   logic [cttf_pkg::POL_W-1:0]  polarity;

   modport source (output valid, operation, var_count, first_var, second_var,
                   third_var, polarity, input ready);
   modport sink   (input valid, operation, var_count, first_var, second_var,
                   third_var, polarity, output ready);
endinterface

interface cttf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cttf_pkg::COUNT_W-1:0]  live_count;
   logic                          is_empty;

   modport source (output valid, live_count, is_empty, input ready);
   modport sink   (input valid, live_count, is_empty, output ready);
endinterface

// File: hdl/cttf_cell.sv
// One cell of the filter row: holds one 64-bit table word, applies each
// item to it and adds its bit count to the running sum. Depends on cttf_pkg.
`timescale 1ns / 1ps

module cttf_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  cttf_pkg::item_type            item_prev,
   input  logic [cttf_pkg::COUNT_W-1:0]  sum_prev,
   output cttf_pkg::item_type            item_next,
   output logic [cttf_pkg::COUNT_W-1:0]  sum_next
);

   localparam logic [cttf_pkg::WORD_IDX_W-1:0] WORD_IDX =
      cttf_pkg::WORD_IDX_W'(CELL_INDEX);

   logic [cttf_pkg::WORD_W-1:0]   word_ff, word_in;
   cttf_pkg::item_type            item_ff;
   logic [cttf_pkg::COUNT_W-1:0]  sum_ff, sum_in;
   logic [cttf_pkg::WORD_W-1:0]   keep;

   always_comb begin
      keep = cttf_pkg::lit_keep(item_prev.var_a, item_prev.pol[0], WORD_IDX)
           | cttf_pkg::lit_keep(item_prev.var_b, item_prev.pol[1], WORD_IDX)
           | cttf_pkg::lit_keep(item_prev.var_c, item_prev.pol[2], WORD_IDX);
      word_in = word_ff;
      if (item_prev.valid) begin
         case (item_prev.op)
            cttf_pkg::OP_INIT: begin
               // word i is set when i < 2^shift
               word_in = ((WORD_IDX >> item_prev.shift) == '0) ? '1 : '0;
            end
            cttf_pkg::OP_CLAUSE: begin
               word_in = word_ff & keep;
            end
            default: begin
               word_in = word_ff;
            end
         endcase
      end
      sum_in = sum_prev + cttf_pkg::COUNT_W'(cttf_pkg::pop64(word_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff       <= '0;
         item_ff.valid <= 1'b0;
      end else if (advance) begin
         word_ff <= word_in;
         item_ff <= item_prev;
         sum_ff  <= sum_in;
      end
   end

   assign item_next = item_ff;
   assign sum_next  = sum_ff;

endmodule

// File: hdl/clause_truth_table_filter.sv
// Top level of the clause truth table filter: a row of table-word cells and
// an output register. Depends on cttf_pkg, cttf_req_if/cttf_rsp_if and cttf_cell.
`timescale 1ns / 1ps

// The 1024-entry truth table is split into 2^(MAX_VARS-6) cells of 64 bits
// (16 at the default). An item enters the first cell and moves one cell per
// cycle while the row advances; each cell updates its word and adds its
// bit count to the running total, and the last cell's total is registered
// in the output register. A new item is taken every cycle; the row only
// stops when a finished result sits in the output register, rsp_chan.ready is
// low and another result arrives behind it.
module clause_truth_table_filter #(
   parameter int MAX_VARS = cttf_pkg::MAX_VARS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   cttf_req_if.sink   req_chan,
   cttf_rsp_if.source rsp_chan
);

   localparam int CELL_COUNT = 1 << (MAX_VARS - cttf_pkg::LANE_VARS);
   localparam logic [cttf_pkg::VAR_W-1:0] MAX_VARS_W = cttf_pkg::VAR_W'(MAX_VARS);
   localparam logic [cttf_pkg::SHIFT_W-1:0] MAX_SHIFT =
      cttf_pkg::SHIFT_W'(MAX_VARS - cttf_pkg::LANE_VARS);

   cttf_pkg::item_type            item_chain [CELL_COUNT+1];
   logic [cttf_pkg::COUNT_W-1:0]  sum_chain  [CELL_COUNT+1];
   logic                          advance;
   logic [cttf_pkg::VAR_W-1:0]    count_off;
   logic [cttf_pkg::SHIFT_W-1:0]  shift;

   logic                          out_valid_ff, out_valid_in;
   logic [cttf_pkg::COUNT_W-1:0]  out_count_ff;
   logic                          out_empty_ff;
   logic                          last_valid;

   assign last_valid = item_chain[CELL_COUNT].valid;
   assign advance    = !(last_valid && out_valid_ff && !rsp_chan.ready);
   assign req_chan.ready = advance;

   // clamp var_count to 6..MAX_VARS, keep n-6
   always_comb begin
      count_off = req_chan.var_count - cttf_pkg::VAR_LANE_LIMIT;
      if (req_chan.var_count < cttf_pkg::VAR_LANE_LIMIT) begin
         shift = '0;
      end else if (req_chan.var_count > MAX_VARS_W) begin
         shift = MAX_SHIFT;
      end else begin
         shift = count_off[cttf_pkg::SHIFT_W-1:0];
      end
   end

   assign item_chain[0].valid = req_chan.valid && advance;
   assign item_chain[0].op    = cttf_pkg::op_type'(req_chan.operation);
   assign item_chain[0].shift = shift;
   assign item_chain[0].var_a = req_chan.first_var;
   assign item_chain[0].var_b = req_chan.second_var;
   assign item_chain[0].var_c = req_chan.third_var;
   assign item_chain[0].pol   = req_chan.polarity;
   assign sum_chain[0]        = '0;

   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      cttf_cell #(
         .CELL_INDEX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .item_prev (item_chain[i]),
         .sum_prev  (sum_chain[i]),
         .item_next (item_chain[i+1]),
         .sum_next  (sum_chain[i+1])
      );
   end

   always_comb begin
      if (advance && last_valid) begin
         out_valid_in = 1'b1;
      end else begin
         out_valid_in = out_valid_ff && !rsp_chan.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && last_valid) begin
         out_count_ff <= sum_chain[CELL_COUNT];
         out_empty_ff <= (sum_chain[CELL_COUNT] == '0);
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.live_count = out_count_ff;
   assign rsp_chan.is_empty   = out_empty_ff;

endmodule

// File: hdl/cttf_checker.sv
// Port-level checks of the clause truth table filter, bound to the top level.
// Depends on clause_truth_table_filter_macros.svh and cttf_pkg.
`timescale 1ns / 1ps
`include "clause_truth_table_filter_macros.svh"

module cttf_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [cttf_pkg::COUNT_W-1:0]  live_count,
   input logic                          is_empty
);

   logic                          rsp_stall;
   logic [cttf_pkg::COUNT_W:0]    rsp_word;

   assign rsp_stall = rsp_valid && !rsp_ready && !reset;
   assign rsp_word  = {live_count, is_empty};

   // a result waiting for the sink stays put
   `CTTF_ASSERT_IMPL(a_rsp_hold, clock, reset, $past(rsp_stall), rsp_valid && $stable(rsp_word))

   // empty flag agrees with the count
   `CTTF_ASSERT_IMPL(a_empty_match, clock, reset, rsp_valid, is_empty == (live_count == '0))

   // never more survivors than table entries
   `CTTF_ASSERT_IMPL(a_count_range, clock, reset, rsp_valid, live_count <= 11'd1024)

   // reset leaves no result pending
   `CTTF_ASSERT_NEXT(a_reset_clear, clock, reset, !rsp_valid)

endmodule

bind clause_truth_table_filter cttf_checker u_cttf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .live_count (rsp_chan.live_count),
   .is_empty   (rsp_chan.is_empty)
);

// File: bench/tb_top.sv
// Self-checking bench for clause_truth_table_filter: keeps a 1024-entry truth table
// of its own, predicts live_count/is_empty per item and checks every response.
// Depends on cttf_pkg, cttf_req_if/cttf_rsp_if and the filter RTL.
`timescale 1ns / 1ps

module tb_top;

   localparam int TABLE_SIZE    = 1 << cttf_pkg::MAX_VARS_DEF;
   localparam int RANDOM_ITEMS  = 1030;
   localparam int STALL_LIMIT   = 5000;
   localparam int DRAIN_CYCLES  = 40;
   localparam int PRESSURE_HOLD = 80;

   typedef struct {
      cttf_pkg::op_type           op;
      logic [cttf_pkg::VAR_W-1:0] var_count;
      logic [cttf_pkg::VAR_W-1:0] first_var;
      logic [cttf_pkg::VAR_W-1:0] second_var;
      logic [cttf_pkg::VAR_W-1:0] third_var;
      logic [cttf_pkg::POL_W-1:0] polarity;
   } filter_item_type;

   typedef struct {
      logic [cttf_pkg::COUNT_W-1:0] live_count;
      logic                         is_empty;
   } table_result_type;

   logic clock;
   logic reset;

   cttf_req_if req_bus();
   cttf_rsp_if rsp_bus();

   clause_truth_table_filter DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   filter_item_type    pending_items[$];
   table_result_type   expected_results[$];
   logic [TABLE_SIZE-1:0] live_set;
   int unsigned     items_taken;
   int unsigned     total_items;
   int unsigned     mismatch_count;
   int unsigned     pressure_point;
   int unsigned     hold_cycles;
   bit              pressure_done;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Literal on variable v for table entry k; variables past the table read as 0.
   function automatic bit literal_holds(int unsigned k, logic [cttf_pkg::VAR_W-1:0] v,
                                        logic negated);
      bit value;
      value = (v < cttf_pkg::MAX_VARS_DEF) ? bit'((k >> v) & 1) : 1'b0;
      return negated ? value : !value;
   endfunction

   function automatic table_result_type filter_table(filter_item_type it);
      int unsigned n;
      int unsigned k;
      table_result_type res;
      if (it.op == cttf_pkg::OP_INIT) begin
         n = it.var_count;
         if (n < 6) n = 6;
         if (n > cttf_pkg::MAX_VARS_DEF) n = cttf_pkg::MAX_VARS_DEF;
         for (k = 0; k < TABLE_SIZE; k++) live_set[k] = (k < (1 << n));
      end else begin
         for (k = 0; k < TABLE_SIZE; k++) begin
            if (!(literal_holds(k, it.first_var, it.polarity[0]) ||
                  literal_holds(k, it.second_var, it.polarity[1]) ||
                  literal_holds(k, it.third_var, it.polarity[2])))
               live_set[k] = 1'b0;
         end
      end
      res.live_count = cttf_pkg::COUNT_W'($countones(live_set));
      res.is_empty   = (res.live_count == '0);
      return res;
   endfunction

   // Idle phase: sender light/receiver heavy, then swapped, then none.
   function automatic int idle_phase();
      if (items_taken * 3 < total_items) return 0;
      if (items_taken * 3 < total_items * 2) return 1;
      return 2;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d, expected %0d (item %0d)", what, got, want,
               items_taken);
      mismatch_count++;
   endtask

   task automatic push_init(int unsigned n);
      filter_item_type it;
      it.op         = cttf_pkg::OP_INIT;
      it.var_count  = cttf_pkg::VAR_W'(n);
      it.first_var  = cttf_pkg::VAR_W'($urandom_range(15));
      it.second_var = cttf_pkg::VAR_W'($urandom_range(15));
      it.third_var  = cttf_pkg::VAR_W'($urandom_range(15));
      it.polarity   = cttf_pkg::POL_W'($urandom_range(7));
      pending_items.push_back(it);
   endtask

   task automatic push_clause(int unsigned a, int unsigned b, int unsigned c,
                              int unsigned pol);
      filter_item_type it;
      it.op         = cttf_pkg::OP_CLAUSE;
      it.var_count  = cttf_pkg::VAR_W'($urandom_range(15));
      it.first_var  = cttf_pkg::VAR_W'(a);
      it.second_var = cttf_pkg::VAR_W'(b);
      it.third_var  = cttf_pkg::VAR_W'(c);
      it.polarity   = cttf_pkg::POL_W'(pol);
      pending_items.push_back(it);
   endtask

   // Driver: head of pending_items stays on the bus until taken.
   always @(posedge clock) begin
      bit fire;
      int idle_pct;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         fire = req_bus.valid && req_bus.ready;
         if (fire) begin
            expected_results.push_back(filter_table(pending_items[0]));
            void'(pending_items.pop_front());
            items_taken++;
         end
         if (!req_bus.valid || fire) begin
            case (idle_phase())
               0: idle_pct = 26;
               1: idle_pct = 53;
               default: idle_pct = 0;
            endcase
            if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
               req_bus.valid      <= 1'b1;
               req_bus.operation  <= pending_items[0].op;
               req_bus.var_count  <= pending_items[0].var_count;
               req_bus.first_var  <= pending_items[0].first_var;
               req_bus.second_var <= pending_items[0].second_var;
               req_bus.third_var  <= pending_items[0].third_var;
               req_bus.polarity   <= pending_items[0].polarity;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor and response-side backpressure.
   always @(posedge clock) begin
      table_result_type want;
      int idle_pct;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected item live_count", rsp_bus.live_count, -1);
            end else begin
               want = expected_results.pop_front();
               if (rsp_bus.live_count !== want.live_count)
                  report_mismatch("live_count", rsp_bus.live_count, want.live_count);
               if (rsp_bus.is_empty !== want.is_empty)
                  report_mismatch("is_empty", rsp_bus.is_empty, want.is_empty);
            end
         end
         // long hold in the no-idle phase so the pipe fills and backs up
         if (!pressure_done && items_taken >= pressure_point) begin
            hold_cycles   = PRESSURE_HOLD;
            pressure_done = 1'b1;
         end
         case (idle_phase())
            0: idle_pct = 53;
            1: idle_pct = 26;
            default: idle_pct = 0;
         endcase
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   // Watchdog: too long without any item moving while work is outstanding.
   initial begin
      int unsigned stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (pending_items.size() == 0 && expected_results.size() == 0))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("tb_top NOT OK");
      $finish;
   end

   initial begin
      int unsigned n;
      int unsigned clauses;
      int unsigned a, b, c;
      int unsigned generated;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.operation  = cttf_pkg::OP_INIT;
      req_bus.var_count  = '0;
      req_bus.first_var  = '0;
      req_bus.second_var = '0;
      req_bus.third_var  = '0;
      req_bus.polarity   = '0;
      rsp_bus.ready      = 1'b0;
      items_taken        = 0;
      mismatch_count     = 0;
      hold_cycles        = 0;
      pressure_done      = 1'b0;
      live_set           = '0;

      // directed: clause on the reset table, clamping, out-of-range variables,
      // tautologies, all-negated clauses and every polarity
      push_clause(1, 2, 3, 0);
      push_init(10);
      push_clause(0, 0, 0, 0);
      push_clause(0, 0, 0, 7);
      push_init(15);
      push_clause(9, 9, 9, 7);
      push_clause(5, 6, 15, 3);
      push_clause(10, 12, 15, 7);
      push_init(0);
      push_clause(5, 6, 9, 0);
      push_clause(6, 7, 8, 7);
      push_init(6);
      push_clause(3, 3, 4, 2);
      push_clause(0, 1, 2, 0);
      push_init(8);
      push_clause(7, 6, 5, 5);
      push_clause(1, 4, 2, 6);
      push_clause(8, 9, 11, 4);
      push_init(9);
      push_clause(2, 8, 14, 1);
      push_init(7);
      push_clause(9, 15, 4, 7);

      // random: an init followed by a run of clauses over its variables
      generated = 0;
      while (generated < RANDOM_ITEMS) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(10, 6);
         push_init(n);
         generated++;
         if (n < 6) n = 6;
         if (n > cttf_pkg::MAX_VARS_DEF) n = cttf_pkg::MAX_VARS_DEF;
         clauses = $urandom_range(14, 1);
         repeat (clauses) begin
            a = ($urandom_range(99) < 85) ? $urandom_range(n - 1) : $urandom_range(15);
            b = ($urandom_range(99) < 85) ? $urandom_range(n - 1) : $urandom_range(15);
            c = ($urandom_range(99) < 85) ? $urandom_range(n - 1) : $urandom_range(15);
            push_clause(a, b, c, $urandom_range(7));
            generated++;
         end
      end
      total_items    = pending_items.size();
      pressure_point = total_items - 120;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
